@@ hw/rtl/slm_pkg.sv @@
package slm_pkg;

   // Fixed widths of the channel fields
   localparam int ACT_W  = 2;
   localparam int DATA_W = 32;

   // Defaults for the top-level parameters
   localparam int DEF_LIST_DEPTH  = 32;
   localparam int DEF_VALUE_WIDTH = 32;

   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD_A = 2'd0,
      ACT_LOAD_B = 2'd1,
      ACT_MERGE  = 2'd2
   } action_type;

endpackage

@@ hw/rtl/slm_ram.sv @@
module slm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/slm_cmp.sv @@
module slm_cmp #(
   parameter int WIDTH = 32
) (
   input  logic signed [WIDTH-1:0] head_a,
   input  logic signed [WIDTH-1:0] head_b,
   input  logic                    a_avail,
   input  logic                    b_avail,
   output logic                    take_b
);

   // Take B when A is used up, or when B's head is strictly smaller;
   // ties go to A.
   always_comb begin
      take_b = !a_avail || (b_avail && (head_a > head_b));
   end

endmodule

@@ hw/rtl/sorted_list_merge.sv @@
// Two-way merge of two ascending lists of signed values.
//
// Request channel (req_valid / req_stall, req_action, req_value): an item
// with action load A or load B appends req_value to that list and gives no
// result; a load into a full list is dropped and sets a sticky drop flag.
// A merge item streams every stored value in ascending order on the
// response channel (rsp_valid / rsp_stall), ties taking list A first, with
// rsp_last on the final item and rsp_dropped carrying the drop flag. A
// merge of two empty lists gives a single item with rsp_empty_res set and
// a zero value. Action code 3 is accepted and ignored.
//
// Timing: loads are taken one per cycle while no merge is running. A merge
// holds req_stall high while in ST_MERGE, until its final item is issued.
// Its first item is issued from ST_MERGE, entered once the merge is taken,
// and registered on the output: the read ports already present both list
// heads, so the single shared comparator gives one item a cycle. While
// rsp_stall is high the pending item holds and the merge pauses. After the
// last item both lists and the drop flag are empty again.
// Reset (synchronous, active high) empties both lists and clears the flag
// and the output valid; the list RAMs themselves are not cleared.
module sorted_list_merge #(
   parameter int LIST_DEPTH  = slm_pkg::DEF_LIST_DEPTH,
   parameter int VALUE_WIDTH = slm_pkg::DEF_VALUE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [slm_pkg::ACT_W-1:0]        req_action,
   input  logic signed [slm_pkg::DATA_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [slm_pkg::DATA_W-1:0] rsp_merged_value,
   output logic                             rsp_last,
   output logic                             rsp_empty_res,
   output logic                             rsp_dropped
);

   import slm_pkg::*;

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int TOT_W = CNT_W + 1;

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]         cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0]         ptr_a_ff, ptr_a_in;
   logic [CNT_W-1:0]         ptr_b_ff, ptr_b_in;
   logic                     drop_ff, drop_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic                     rsp_drop_ff, rsp_drop_in;

   logic                     wr_a, wr_b;
   logic [VALUE_WIDTH-1:0]   wr_value;
   logic [VALUE_WIDTH-1:0]   head_a, head_b, head_sel;
   logic                     a_avail, b_avail, take_b;
   logic                     accept, out_free, is_last;
   logic [TOT_W-1:0]         total, done_next;

   // Take the low VALUE_WIDTH bits of the request, sign-extended if wider
   assign wr_value = VALUE_WIDTH'(req_value);

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign total     = TOT_W'(cnt_a_ff) + TOT_W'(cnt_b_ff);
   assign done_next = TOT_W'(ptr_a_ff) + TOT_W'(ptr_b_ff) + TOT_W'(1);
   assign is_last   = (done_next == total);
   assign a_avail   = (ptr_a_ff < cnt_a_ff);
   assign b_avail   = (ptr_b_ff < cnt_b_ff);
   assign head_sel  = take_b ? head_b : head_a;

   // Read ports follow the next pointer, so the RAM output is always the
   // current head of each list.
   slm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(LIST_DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[IDX_W-1:0]),
      .wr_data (wr_value),
      .rd_addr (ptr_a_in[IDX_W-1:0]),
      .rd_data (head_a)
   );

   slm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(LIST_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[IDX_W-1:0]),
      .wr_data (wr_value),
      .rd_addr (ptr_b_in[IDX_W-1:0]),
      .rd_data (head_b)
   );

   slm_cmp #(.WIDTH(VALUE_WIDTH)) u_cmp (
      .head_a  (head_a),
      .head_b  (head_b),
      .a_avail (a_avail),
      .b_avail (b_avail),
      .take_b  (take_b)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      ptr_a_in     = ptr_a_ff;
      ptr_b_in     = ptr_b_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_drop_in  = rsp_drop_ff;
      wr_a         = 1'b0;
      wr_b         = 1'b0;

      // Drop the output item once the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (action_type'(req_action))
                  ACT_LOAD_A: begin
                     if (cnt_a_ff < CNT_W'(LIST_DEPTH)) begin
                        wr_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + CNT_W'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  ACT_LOAD_B: begin
                     if (cnt_b_ff < CNT_W'(LIST_DEPTH)) begin
                        wr_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + CNT_W'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  ACT_MERGE: begin
                     state_in = ST_MERGE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_drop_in  = drop_ff;
               if (total == '0) begin
                  rsp_value_in = '0;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b1;
               end else begin
                  rsp_value_in = DATA_W'(head_sel);
                  rsp_last_in  = is_last;
                  rsp_empty_in = 1'b0;
                  if (take_b) begin
                     ptr_b_in = ptr_b_ff + CNT_W'(1);
                  end else begin
                     ptr_a_in = ptr_a_ff + CNT_W'(1);
                  end
               end
               // Final item issued: empty both lists and return to idle
               if (total == '0 || is_last) begin
                  cnt_a_in = '0;
                  cnt_b_in = '0;
                  ptr_a_in = '0;
                  ptr_b_in = '0;
                  drop_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ptr_a_ff     <= '0;
         ptr_b_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ptr_a_ff     <= ptr_a_in;
         ptr_b_ff     <= ptr_b_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_empty_res    = rsp_empty_ff;
   assign rsp_dropped      = rsp_drop_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= CNT_W'(LIST_DEPTH)) && (cnt_b_ff <= CNT_W'(LIST_DEPTH)))
      else $error("list count beyond depth");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (ptr_a_ff <= cnt_a_ff) && (ptr_b_ff <= cnt_b_ff))
      else $error("merge pointer past list end");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last)
      else $error("empty result not marked last");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) && out_free && (total == '0 || is_last) |=>
      (cnt_a_ff == '0) && (cnt_b_ff == '0) && !drop_ff && (state_ff == ST_IDLE))
      else $error("lists not cleared after final item");
`endif

endmodule

@@ tb/sorted_list_merge_checker.sv @@
module sorted_list_merge_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [slm_pkg::ACT_W-1:0]         req_action,
   input  logic signed [slm_pkg::DATA_W-1:0] req_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [slm_pkg::DATA_W-1:0] rsp_merged_value,
   input  logic                              rsp_last,
   input  logic                              rsp_empty_res,
   input  logic                              rsp_dropped,
   output int                                error_count,
   output int                                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import slm_pkg::*;

   localparam int DEPTH = DEF_LIST_DEPTH;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     empty_res;
      logic                     dropped;
   } merged_item_type;

   logic signed [DATA_W-1:0] shadow_a [$];
   logic signed [DATA_W-1:0] shadow_b [$];
   logic                     overflow_seen;
   merged_item_type          merged_due [$];

   // Walk both shadow lists, A wins ties, then empty them and the flag.
   function automatic void predict_merge_stream();
      int              ia;
      int              ib;
      int              total;
      int              k;
      merged_item_type r;
      ia = 0;
      ib = 0;
      k = 0;
      total = shadow_a.size() + shadow_b.size();
      if (total == 0) begin
         r.value = '0;
         r.last = 1'b1;
         r.empty_res = 1'b1;
         r.dropped = overflow_seen;
         merged_due = {merged_due, r};
      end
      while (ia < shadow_a.size() || ib < shadow_b.size()) begin
         if (ia < shadow_a.size() &&
             (ib >= shadow_b.size() || shadow_a[ia] <= shadow_b[ib])) begin
            r.value = shadow_a[ia];
            ia++;
         end else begin
            r.value = shadow_b[ib];
            ib++;
         end
         k++;
         r.last = (k == total);
         r.empty_res = 1'b0;
         r.dropped = overflow_seen;
         merged_due = {merged_due, r};
      end
      shadow_a.delete();
      shadow_b.delete();
      overflow_seen = 1'b0;
   endfunction

   always @(posedge clock) begin : watch
      merged_item_type want;
      if (reset) begin
         shadow_a.delete();
         shadow_b.delete();
         merged_due.delete();
         overflow_seen = 1'b0;
         error_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (merged_due.size() == 0) begin
               error_count++;
               $display("%0t: unexpected item value %0d last %0b empty %0b dropped %0b",
                        $time, rsp_merged_value, rsp_last, rsp_empty_res, rsp_dropped);
            end else begin
               want = merged_due.pop_front();
               if (rsp_merged_value !== want.value || rsp_last !== want.last ||
                   rsp_empty_res !== want.empty_res || rsp_dropped !== want.dropped) begin
                  error_count++;
                  $display("%0t: mismatch expected value %0d last %0b empty %0b dropped %0b",
                           $time, want.value, want.last, want.empty_res, want.dropped);
                  $display("%0t:          actual value %0d last %0b empty %0b dropped %0b",
                           $time, rsp_merged_value, rsp_last, rsp_empty_res, rsp_dropped);
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_action)
               ACT_LOAD_A: begin
                  if (shadow_a.size() < DEPTH) shadow_a = {shadow_a, req_value};
                  else overflow_seen = 1'b1;
               end
               ACT_LOAD_B: begin
                  if (shadow_b.size() < DEPTH) shadow_b = {shadow_b, req_value};
                  else overflow_seen = 1'b1;
               end
               ACT_MERGE: predict_merge_stream();
               default: ;
            endcase
         end
      end
      outstanding = merged_due.size();
   end

endmodule

@@ tb/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import slm_pkg::*;

   // The block accepts and ignores this action code
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam int DEPTH = DEF_LIST_DEPTH;
   // Stop the stimulus once roughly this many real items have gone in
   localparam int ITEM_GOAL = 400;
   // Past this point neither side idles any more
   localparam int CALM_AFTER = 320;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [ACT_W-1:0]         req_action;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_merged_value;
   logic                     rsp_last;
   logic                     rsp_empty_res;
   logic                     rsp_dropped;

   int error_count;
   int outstanding;
   int items_sent;
   int quiet_items;
   bit calm;

   sorted_list_merge i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_value (rsp_merged_value),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_dropped      (rsp_dropped)
   );

   sorted_list_merge_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_value (rsp_merged_value),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_dropped      (rsp_dropped),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver back-pressure: alternate stall bursts with free-running
   // stretches; hold the channel open once the run goes calm.
   initial begin : rsp_pacing
      int  burst;
      bit  stalling;
      burst = 0;
      stalling = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (burst == 0) begin
            if (calm) begin
               stalling = 1'b0;
               burst = 1;
            end else begin
               stalling = ($urandom_range(0, 2) == 0);
               burst = stalling ? $urandom_range(1, 10) : $urandom_range(1, 20);
            end
         end
         rsp_stall <= stalling;
         burst--;
      end
   end

   // Present one item at the falling edge and hold it until the block takes
   // it. Now and then drop valid for a burst first, but leave stretches of
   // back-to-back items in between.
   task automatic send(input logic [ACT_W-1:0] action, input logic signed [DATA_W-1:0] value);
      @(negedge clock);
      if (!calm && quiet_items == 0 && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
         quiet_items = $urandom_range(0, 20);
      end else if (quiet_items > 0) begin
         quiet_items--;
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      if (action != ACT_UNUSED) items_sent++;
   endtask

   // Mostly short lists, now and then up to a full one
   function automatic int pick_length();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, DEPTH) : $urandom_range(0, 6);
   endfunction

   // Build two lists, load them interleaved in order and ask for the merge.
   // Lengths above the depth overflow the list and raise the drop flag.
   // Narrow values force plenty of equal heads; noisy runs slip in ignored
   // action codes; unordered runs skip the sort.
   task automatic fill_and_merge(input int len_a, input int len_b, input bit ordered,
                                 input bit narrow, input bit noisy);
      logic signed [DATA_W-1:0] vals [2][64];
      logic signed [DATA_W-1:0] tmp;
      int                       n [2];
      int                       i;
      int                       j;
      int                       l;
      int                       ia;
      int                       ib;
      n[0] = len_a;
      n[1] = len_b;
      for (l = 0; l < 2; l++) begin
         for (i = 0; i < n[l]; i++) begin
            case ($urandom_range(0, 15))
               0: vals[l][i] = VAL_MIN;
               1: vals[l][i] = VAL_MAX;
               default: vals[l][i] = narrow ? int'($urandom_range(0, 8)) - 4 : $urandom();
            endcase
         end
         if (ordered) begin
            for (i = 1; i < n[l]; i++) begin
               tmp = vals[l][i];
               j = i - 1;
               while (j >= 0 && vals[l][j] > tmp) begin
                  vals[l][j + 1] = vals[l][j];
                  j--;
               end
               vals[l][j + 1] = tmp;
            end
         end
      end
      ia = 0;
      ib = 0;
      while (ia < n[0] || ib < n[1]) begin
         if (noisy && $urandom_range(0, 7) == 0) send(ACT_UNUSED, $urandom());
         if (ib >= n[1] || (ia < n[0] && $urandom_range(0, 1) == 1)) begin
            send(ACT_LOAD_A, vals[0][ia]);
            ia++;
         end else begin
            send(ACT_LOAD_B, vals[1][ib]);
            ib++;
         end
      end
      send(ACT_MERGE, $urandom());
   endtask

   initial begin : stimulus
      int pick;
      int len_a;
      int len_b;
      calm = 1'b0;
      items_sent = 0;
      quiet_items = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_LOAD_A;
      req_value = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Merge straight after reset: both lists empty, expect the lone empty item
      send(ACT_MERGE, VAL_MAX);

      // Extremes on both sides with equal heads at the minimum and maximum
      send(ACT_LOAD_A, VAL_MIN);
      send(ACT_LOAD_B, VAL_MIN);
      send(ACT_LOAD_A, -1);
      send(ACT_LOAD_B, 0);
      send(ACT_LOAD_A, 0);
      send(ACT_LOAD_B, 5);
      send(ACT_LOAD_A, VAL_MAX);
      send(ACT_LOAD_B, VAL_MAX);
      send(ACT_MERGE, -1);

      // Ignored action code, then a run with list B alone
      send(ACT_UNUSED, -1);
      send(ACT_LOAD_B, -7);
      send(ACT_LOAD_B, 9);
      send(ACT_MERGE, 0);

      // List A alone, loaded out of order: merged as given
      send(ACT_LOAD_A, 10);
      send(ACT_LOAD_A, -10);
      send(ACT_MERGE, 0);

      // Overflow each list once early on so the drop flag is certain to show
      fill_and_merge(DEPTH + 2, 3, 1'b1, 1'b0, 1'b0);
      fill_and_merge(1, DEPTH + 1, 1'b1, 1'b1, 1'b0);

      while (items_sent < ITEM_GOAL) begin
         if (items_sent > CALM_AFTER) calm = 1'b1;
         pick = $urandom_range(0, 19);
         len_a = pick_length();
         len_b = pick_length();
         if (pick == 0) len_a = DEPTH + $urandom_range(1, 4);
         if (pick == 1) len_b = DEPTH + $urandom_range(1, 4);
         if (pick == 2) begin
            len_a = DEPTH;
            len_b = DEPTH;
         end
         fill_and_merge(len_a, len_b, !(pick == 3 || pick == 4),
                        $urandom_range(0, 2) == 0, pick >= 15);
      end

      // Release the request channel and let the last merge drain
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      // Allow for anything stray after the final expected item
      repeat (100) @(negedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("sorted_list_merge test passed");
      end else begin
         $display("sorted_list_merge test failed");
      end
      $finish;
   end

   // Hang guard: far beyond the slowest legal run
   initial begin
      #5ms;
      $display("sorted_list_merge test failed");
      $finish;
   end

endmodule
